[sv/wtsr_pkg.sv]
// shared types and constants for the wiggle trace span rasterizer
package wtsr_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 8192;
  localparam int unsigned MAX_HEIGHT_DEF = 8192;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned DEFL_W  = 14;
  localparam int unsigned COORD_W = 18;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PIXEL_SCALE      = 3'd0,
    REG_FILL_MODE        = 3'd1,
    REG_REVERSE_POLARITY = 3'd2,
    REG_CLIP_REACH       = 3'd3,
    REG_RASTER_WIDTH     = 3'd4
  } cfg_reg_t;

  localparam logic [1:0] FILL_WIGGLE  = 2'd0;
  localparam logic [1:0] FILL_POS     = 2'd1;
  localparam logic [1:0] FILL_NEG     = 2'd2;
  localparam logic [1:0] FILL_NEG_ALT = 2'd3;

  localparam logic [15:0] PIXEL_SCALE_RST  = 16'd4096;
  localparam logic [1:0]  FILL_MODE_RST    = FILL_WIGGLE;
  localparam logic        REVERSE_RST      = 1'b0;
  localparam logic [12:0] CLIP_REACH_RST   = 13'd16;
  localparam logic [13:0] RASTER_WIDTH_RST = 14'd8192;

  typedef struct packed {
    logic [15:0] pixel_scale;
    logic [1:0]  fill_mode;
    logic        reverse_polarity;
    logic [12:0] clip_reach;
    logic [13:0] raster_width;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  sample_here;
    logic [7:0]  sample_next;
    logic [7:0]  fraction;
    logic [12:0] center_x;
    logic        past_end;
    logic        row_last;
  } item_t;

  typedef struct packed {
    logic [12:0] span_row;
    logic [12:0] span_start;
    logic [13:0] span_length;
    logic        span_draw;
    logic        span_last;
  } span_t;

  typedef struct packed {
    logic signed [DEFL_W-1:0] held_defl;
    logic signed [DEFL_W-1:0] held_ext;
    logic signed [DEFL_W-1:0] cur_defl;
    logic [12:0]              center_x;
    logic [12:0]              held_row;
    logic [12:0]              cur_row;
    logic                     has_held;
    logic                     has_cur;
  } entry_t;

  typedef struct packed {
    logic signed [DEFL_W-1:0] defl;
    logic signed [DEFL_W-1:0] ext;
    logic [12:0]              center_x;
    logic [12:0]              row;
    logic                     last;
  } job_t;

endpackage

[sv/wiggle_trace_span_raster_core.sv]
// top level of the wiggle trace span rasterizer: config registers, front, queue, back
// path: front stages s1, s2, row queue, back stage p, span output register
// throughput: one row per cycle in the front unless the queue is full, one span beat
// per cycle from the back unless stalled; the 4-entry row queue absorbs the difference
// reset (synchronous): registers to defaults, no row pending, row counter zero, queue empty
module wiggle_trace_span_raster_core
  import wtsr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   span_valid,
  input  logic                   span_stall,
  output span_t                  span
);

  cfg_t   cfg;
  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_entry, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_scale      <= PIXEL_SCALE_RST;
      cfg.fill_mode        <= FILL_MODE_RST;
      cfg.reverse_polarity <= REVERSE_RST;
      cfg.clip_reach       <= CLIP_REACH_RST;
      cfg.raster_width     <= RASTER_WIDTH_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PIXEL_SCALE:      cfg.pixel_scale      <= cfg_data;
        REG_FILL_MODE:        cfg.fill_mode        <= cfg_data[1:0];
        REG_REVERSE_POLARITY: cfg.reverse_polarity <= cfg_data[0];
        REG_CLIP_REACH:       cfg.clip_reach       <= cfg_data[12:0];
        REG_RASTER_WIDTH:     cfg.raster_width     <= cfg_data[13:0];
        default: begin
        end
      endcase
    end
  end

  wtsr_front #(
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  wtsr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  wtsr_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .span_valid(span_valid),
    .span_stall(span_stall),
    .span      (span)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("row queue written while full");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("row queue read while empty");

  a_span_nonempty: assert property (@(posedge clk) disable iff (rst)
    span_valid |-> (span.span_draw && span.span_length != 14'd0))
    else $error("span beat with no pixels");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !span_valid)
    else $error("span beat right after reset");

endmodule

[sv/wtsr_queue.sv]
// small fifo of classified rows between front and back
module wtsr_queue
  import wtsr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t head,
  output logic   empty
);

  entry_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full  = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/wtsr_front.sv]
// front end: accepts rows, computes deflection and extension, queues span work
module wtsr_front
  import wtsr_pkg::*;
#(
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   item_valid,
  output logic   item_stall,
  input  item_t  item,
  input  logic   q_full,
  output logic   q_push,
  output entry_t q_entry
);

  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
  localparam logic [ROW_W-1:0] RowTop = ROW_W'(MAX_HEIGHT - 1);

  // stage 1
  logic               s1_valid;
  logic signed [16:0] s1_operand;
  logic               s1_past;
  logic [12:0]        s1_center;
  logic               s1_last;

  // stage 2
  logic               s2_valid;
  logic signed [33:0] s2_product;
  logic               s2_past;
  logic [12:0]        s2_center;
  logic               s2_last;

  // row state
  logic signed [DEFL_W-1:0] held_defl;
  logic                     held_valid;
  logic [ROW_W-1:0]         row_count;

  logic s1_ready, s2_ready, s1_fire, s2_fire, item_accept;

  logic signed [8:0]  here_off;
  logic signed [8:0]  step;
  logic signed [17:0] frac_term;
  logic signed [17:0] interp;
  logic signed [16:0] operand_next;

  logic                     neg;
  logic [33:0]              mag_full;
  logic [33:0]              rounded;
  logic [DEFL_W-1:0]        mag;
  logic signed [DEFL_W-1:0] cur_defl;
  logic signed [DEFL_W:0]   defl_gap;
  logic signed [DEFL_W:0]   gap_up;
  logic signed [DEFL_W:0]   gap_down;
  logic signed [DEFL_W-1:0] held_ext;
  logic [ROW_W-1:0]         row_inc;

  assign s2_fire     = s2_valid && !q_full;
  assign s2_ready    = !s2_valid || s2_fire;
  assign s1_fire     = s1_valid && s2_ready;
  assign s1_ready    = !s1_valid || s2_ready;
  assign item_stall  = !s1_ready;
  assign item_accept = item_valid && s1_ready;

  // interpolated sample in q.8, or the bare sample for a past-end row
  always_comb begin
    here_off     = $signed({1'b0, item.sample_here} - 9'd128);
    step         = $signed({1'b0, item.sample_next} - {1'b0, item.sample_here});
    frac_term    = $signed({1'b0, item.fraction}) * step;
    interp       = {here_off[8], here_off, 8'b0} + frac_term;
    operand_next = item.past_end ? {{8{here_off[8]}}, here_off} : interp[16:0];
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_operand <= operand_next;
      s1_past    <= item.past_end;
      s1_center  <= item.center_x;
      s1_last    <= item.row_last;
    end
    if (s1_fire) begin
      s2_product <= s1_operand * $signed({1'b0, cfg.pixel_scale});
      s2_past    <= s1_past;
      s2_center  <= s1_center;
      s2_last    <= s1_last;
    end
  end

  // rounding (past-end rows truncate), polarity and joining extension
  always_comb begin
    neg      = s2_product[33];
    mag_full = neg ? -s2_product : s2_product;
    rounded  = mag_full + (34'd1 << 19);
    mag      = s2_past ? mag_full[25:12] : rounded[33:20];
    cur_defl = (neg ^ cfg.reverse_polarity) ? -$signed(mag) : $signed(mag);
    defl_gap = {cur_defl[DEFL_W-1], cur_defl} - {held_defl[DEFL_W-1], held_defl};
    gap_up   = defl_gap + (DEFL_W+1)'(1);
    gap_down = defl_gap - (DEFL_W+1)'(1);
    if (defl_gap < 0) begin
      held_ext = gap_up[DEFL_W-1:0];
    end else if (defl_gap > 0) begin
      held_ext = gap_down[DEFL_W-1:0];
    end else begin
      held_ext = '0;
    end
    row_inc = (row_count == RowTop) ? '0 : row_count + 1'b1;
  end

  assign q_push = s2_fire && (held_valid || s2_last);

  always_comb begin
    q_entry.held_defl = held_defl;
    q_entry.held_ext  = held_ext;
    q_entry.cur_defl  = cur_defl;
    q_entry.center_x  = s2_center;
    q_entry.held_row  = 13'(row_count);
    q_entry.cur_row   = held_valid ? 13'(row_inc) : 13'(row_count);
    q_entry.has_held  = held_valid;
    q_entry.has_cur   = s2_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      held_defl  <= '0;
      held_valid <= 1'b0;
      row_count  <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid <= item_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s2_fire) begin
        if (s2_last) begin
          held_defl  <= '0;
          held_valid <= 1'b0;
          row_count  <= '0;
        end else begin
          held_defl  <= cur_defl;
          held_valid <= 1'b1;
          if (held_valid) begin
            row_count <= row_inc;
          end
        end
      end
    end
  end

endmodule

[sv/wtsr_back.sv]
// back end: expands queued rows into spans, applies fill mode and clipping
module wtsr_back
  import wtsr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   q_empty,
  input  entry_t q_head,
  output logic   q_pop,
  output logic   span_valid,
  input  logic   span_stall,
  output span_t  span
);

  localparam logic [16:0] WidthCap = 17'(MAX_WIDTH);

  logic phase;
  logic sel_cur, entry_done, issue;
  job_t job;

  logic o_ready, p_ready, p_advance;

  logic                      p_valid;
  logic signed [COORD_W-1:0] p_lo;
  logic signed [COORD_W-1:0] p_hi;
  logic signed [COORD_W-1:0] p_len;
  logic signed [COORD_W-1:0] p_xmin;
  logic signed [COORD_W-1:0] p_xmax;
  logic [12:0]               p_row;
  logic                      p_last;

  logic signed [COORD_W-1:0] xs_c, d_c, e_c, de_c;
  logic signed [COORD_W-1:0] g_start, g_end;
  logic signed [COORD_W-1:0] lo_next, hi_next, len_next;
  logic signed [COORD_W-1:0] reach_c, xmin_raw, xmax_raw, w_last;
  logic signed [COORD_W-1:0] xmin_next, xmax_next;
  logic                      width_over;
  logic [13:0]               w_clamped, w_eff;

  logic signed [COORD_W-1:0] c_start, c_len;

  // span selection out of the queue head
  assign sel_cur    = !q_head.has_held || phase;
  assign entry_done = sel_cur || !q_head.has_cur;
  assign o_ready    = !span_valid || !span_stall;
  assign p_ready    = !p_valid || o_ready;
  assign p_advance  = p_valid && o_ready;
  assign issue      = !q_empty && p_ready;
  assign q_pop      = issue && entry_done;

  always_comb begin
    job.defl     = sel_cur ? q_head.cur_defl : q_head.held_defl;
    job.ext      = sel_cur ? '0 : q_head.held_ext;
    job.center_x = q_head.center_x;
    job.row      = sel_cur ? q_head.cur_row : q_head.held_row;
    job.last     = sel_cur || !q_head.has_cur;
  end

  // span geometry by fill mode
  always_comb begin
    xs_c    = $signed({5'b0, job.center_x});
    d_c     = {{(COORD_W-DEFL_W){job.defl[DEFL_W-1]}}, job.defl};
    e_c     = {{(COORD_W-DEFL_W){job.ext[DEFL_W-1]}}, job.ext};
    de_c    = d_c + e_c;
    g_start = xs_c + d_c;
    g_end   = xs_c + de_c;
    if (cfg.fill_mode == FILL_POS && d_c > 0) begin
      g_start = (de_c < 0) ? xs_c + de_c : xs_c;
      g_end   = (e_c > 0) ? xs_c + de_c : xs_c + d_c;
    end else if ((cfg.fill_mode inside {FILL_NEG, FILL_NEG_ALT}) && d_c < 0) begin
      g_start = (de_c > 0) ? xs_c + de_c : xs_c;
      g_end   = (e_c < 0) ? xs_c + de_c : xs_c + d_c;
    end
    if (g_start < g_end) begin
      lo_next  = g_start;
      hi_next  = g_end;
      len_next = g_end - g_start + COORD_W'(1);
    end else begin
      lo_next  = g_end;
      hi_next  = g_start;
      len_next = g_start - g_end + COORD_W'(1);
    end
  end

  // clip window
  always_comb begin
    width_over = {3'b0, cfg.raster_width} > WidthCap;
    w_clamped  = width_over ? WidthCap[13:0] : cfg.raster_width;
    w_eff      = (w_clamped == '0) ? 14'd1 : w_clamped;
    w_last     = $signed({4'b0, w_eff}) - COORD_W'(1);
    reach_c    = $signed({5'b0, cfg.clip_reach});
    xmin_raw   = xs_c - reach_c;
    xmax_raw   = xs_c + reach_c;
    xmin_next  = (xmin_raw < 0) ? '0 : xmin_raw;
    xmax_next  = (xmax_raw > w_last) ? w_last : xmax_raw;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_lo   <= lo_next;
      p_hi   <= hi_next;
      p_len  <= len_next;
      p_xmin <= xmin_next;
      p_xmax <= xmax_next;
      p_row  <= job.row;
      p_last <= job.last;
    end
  end

  always_comb begin
    c_start = p_lo;
    c_len   = p_len;
    if (p_hi < p_xmin) begin
      c_start = p_xmin;
      c_len   = COORD_W'(1);
    end else if (p_lo < p_xmin) begin
      c_start = p_xmin;
      c_len   = p_len - (p_xmin - p_lo);
    end
    if (c_start > p_xmax) begin
      c_start = p_xmax;
      c_len   = COORD_W'(1);
    end else if (c_start + c_len - COORD_W'(1) > p_xmax) begin
      c_len = p_xmax - c_start + COORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (p_advance) begin
      span.span_row    <= p_row;
      span.span_start  <= c_start[12:0];
      span.span_length <= c_len[13:0];
      span.span_draw   <= (c_len > 0);
      span.span_last   <= p_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= 1'b0;
      p_valid    <= 1'b0;
      span_valid <= 1'b0;
    end else begin
      if (issue) begin
        phase <= !entry_done;
      end
      if (p_ready) begin
        p_valid <= issue;
      end
      if (o_ready) begin
        span_valid <= p_valid;
      end
    end
  end

endmodule

[bench/wtsr_span_checker.sv]
// span checker: watches the register port and both channels, predicts every span and compares
`timescale 1ns / 100ps

module wtsr_span_checker
  import wtsr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  input  logic                   item_stall,
  input  item_t                  item,
  input  logic                   span_valid,
  input  logic                   span_stall,
  input  span_t                  span,
  output int                     mismatches,
  output int                     spans_owed
);

  logic [15:0] scale;
  logic [1:0]  fill;
  logic        flip;
  logic [12:0] reach;
  logic [13:0] width;

  longint held_defl;
  bit     held_valid;
  int     row_count;

  span_t spans_due[$];

  function automatic longint row_deflection(item_t r);
    longint sa, v, mag;
    bit     neg;
    sa = longint'(r.sample_here) - 128;
    if (r.past_end) begin
      v = sa * longint'(scale);
      neg = v < 0;
      mag = neg ? -v : v;
      mag = mag >> 12;
    end else begin
      v = sa * 256 + longint'(r.fraction) * (longint'(r.sample_next) - longint'(r.sample_here));
      v = v * longint'(scale);
      neg = v < 0;
      mag = neg ? -v : v;
      mag = (mag + (longint'(1) << 19)) >> 20;
    end
    if (neg) mag = -mag;
    if (flip) mag = -mag;
    return mag;
  endfunction

  function automatic span_t span_of(longint d, longint ext, longint xs, int row, bit last);
    longint w, start, stop, len, lo, hi, t;
    span_t  s;
    w = longint'(width);
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    if (w < 1) w = 1;
    if (fill == FILL_POS && d > 0) begin
      start = xs;
      stop = ext > 0 ? xs + d + ext : xs + d;
      if (ext + d < 0) start += ext + d;
    end else if ((fill == FILL_NEG || fill == FILL_NEG_ALT) && d < 0) begin
      start = xs;
      stop = ext < 0 ? xs + d + ext : xs + d;
      if (ext + d > 0) start += ext + d;
    end else begin
      start = xs + d;
      stop = start + ext;
    end
    if (start < stop) begin
      len = stop - start + 1;
    end else begin
      t = stop;
      len = start - stop + 1;
      stop = start;
      start = t;
    end
    lo = xs - longint'(reach);
    if (lo < 0) lo = 0;
    hi = xs + longint'(reach);
    if (hi > w - 1) hi = w - 1;
    if (stop < lo) begin
      start = lo;
      len = 1;
    end else if (start < lo) begin
      len -= lo - start;
      start = lo;
    end
    if (start > hi) begin
      start = hi;
      len = 1;
    end else if (start + len - 1 > hi) begin
      len = hi - start + 1;
    end
    s.span_row    = row[12:0];
    s.span_start  = start[12:0];
    s.span_length = len[13:0];
    s.span_draw   = len > 0;
    s.span_last   = last;
    return s;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin : watch
    span_t  want;
    longint cur, ext;
    if (rst) begin
      scale      = PIXEL_SCALE_RST;
      fill       = FILL_MODE_RST;
      flip       = REVERSE_RST;
      reach      = CLIP_REACH_RST;
      width      = RASTER_WIDTH_RST;
      held_defl  = 0;
      held_valid = 0;
      row_count  = 0;
      spans_due.delete();
    end else begin
      if (span_valid && !span_stall) begin
        if (spans_due.size() == 0) begin
          $error("span beat with nothing expected: row %0d start %0d length %0d",
                 span.span_row, span.span_start, span.span_length);
          mismatches++;
        end else begin
          want = spans_due.pop_front();
          check_field("span_row", 16'(want.span_row), 16'(span.span_row));
          check_field("span_start", 16'(want.span_start), 16'(span.span_start));
          check_field("span_length", 16'(want.span_length), 16'(span.span_length));
          check_field("span_draw", 16'(want.span_draw), 16'(span.span_draw));
          check_field("span_last", 16'(want.span_last), 16'(span.span_last));
        end
      end
      if (item_valid && !item_stall) begin
        cur = row_deflection(item);
        if (held_valid) begin
          if (held_defl > cur) ext = cur - held_defl + 1;
          else if (held_defl < cur) ext = cur - held_defl - 1;
          else ext = 0;
          spans_due.push_back(span_of(held_defl, ext, longint'(item.center_x), row_count,
                                      !item.row_last));
          row_count = (row_count + 1 >= MAX_HEIGHT_DEF) ? 0 : row_count + 1;
        end
        if (item.row_last) begin
          spans_due.push_back(span_of(cur, 0, longint'(item.center_x), row_count, 1'b1));
          held_valid = 0;
          held_defl  = 0;
          row_count  = 0;
        end else begin
          held_defl  = cur;
          held_valid = 1;
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_PIXEL_SCALE:      scale = cfg_data;
          REG_FILL_MODE:        fill  = cfg_data[1:0];
          REG_REVERSE_POLARITY: flip  = cfg_data[0];
          REG_CLIP_REACH:       reach = cfg_data[12:0];
          REG_RASTER_WIDTH:     width = cfg_data[13:0];
          default: ;
        endcase
      end
    end
    spans_owed = spans_due.size();
  end

endmodule

[bench/tb_wiggle_trace_span_raster_core.sv]
// testbench top for the wiggle trace span rasterizer: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_wiggle_trace_span_raster_core;
  import wtsr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   item_valid;
  logic                   item_stall;
  item_t                  item_beat;
  logic                   span_valid;
  logic                   span_stall;
  span_t                  span_beat;

  int mismatches;
  int spans_owed;
  int cycle_count;
  int rows_sent;
  int stall_left;
  int long_hold;
  bit calm;

  wiggle_trace_span_raster_core DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item_beat),
    .span_valid (span_valid),
    .span_stall (span_stall),
    .span       (span_beat)
  );

  wtsr_span_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item_beat),
    .span_valid (span_valid),
    .span_stall (span_stall),
    .span       (span_beat),
    .mismatches (mismatches),
    .spans_owed (spans_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // span receiver: random stall per beat, plus a long hold-off on request
  initial begin
    span_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (span_valid && !span_stall) stall_left = calm ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (long_hold > 0) begin
        span_stall = 1'b1;
        long_hold--;
      end else if (stall_left > 0) begin
        span_stall = 1'b1;
        stall_left--;
      end else begin
        span_stall = 1'b0;
      end
    end
  end

  function automatic item_t mk(int a, int b, int f, int cx, bit pe, bit rl);
    item_t r;
    r.sample_here = a[7:0];
    r.sample_next = b[7:0];
    r.fraction    = f[7:0];
    r.center_x    = cx[12:0];
    r.past_end    = pe;
    r.row_last    = rl;
    return r;
  endfunction

  function automatic logic [12:0] pick_center();
    case ($urandom_range(0, 5))
      0:       return 13'd0;
      1:       return 13'd8191;
      2:       return 13'($urandom_range(0, 64));
      3:       return 13'($urandom_range(0, 400));
      default: return 13'($urandom_range(0, 8191));
    endcase
  endfunction

  task automatic send_row(item_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_beat  = r;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    rows_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    item_valid = 1'b0;
    while (spans_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic put_reg(cfg_reg_t idx, logic [15:0] v);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(negedge clk);
  endtask

  task automatic set_config(int scale, int fill, int flip, int reach, int width);
    put_reg(REG_PIXEL_SCALE, 16'(scale));
    put_reg(REG_FILL_MODE, 16'(fill));
    put_reg(REG_REVERSE_POLARITY, 16'(flip));
    put_reg(REG_CLIP_REACH, 16'(reach));
    put_reg(REG_RASTER_WIDTH, 16'(width));
    cfg_write = 1'b0;
  endtask

  task automatic random_config();
    int scale, reach, width;
    case ($urandom_range(0, 5))
      0:       scale = 0;
      1:       scale = 65535;
      2:       scale = 4096;
      default: scale = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 5))
      0:       reach = 0;
      1:       reach = 8191;
      2, 3:    reach = $urandom_range(0, 64);
      default: reach = $urandom_range(0, 8191);
    endcase
    case ($urandom_range(0, 5))
      0:       width = 0;
      1:       width = 16383;
      2:       width = 8192;
      3:       width = $urandom_range(1, 64);
      4:       width = $urandom_range(1, 8192);
      default: width = $urandom_range(0, 16383);
    endcase
    set_config(scale, $urandom_range(0, 3), $urandom_range(0, 1), reach, width);
  endtask

  // tidy traces keep one center and end with a last row, past-end rows only at the tail
  task automatic random_trace(bit tidy, int n);
    logic [12:0] cx;
    logic [7:0]  s;
    item_t       r;
    int          tail, t;
    cx = pick_center();
    s = 8'($urandom);
    tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    for (int i = 0; i < n; i++) begin
      r.sample_here = s;
      if ($urandom_range(0, 3) == 0) begin
        s = 8'($urandom);
      end else begin
        t = int'(s) + int'($urandom_range(0, 48)) - 24;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        s = t[7:0];
      end
      r.sample_next = s;
      r.fraction    = 8'($urandom);
      r.center_x    = tidy ? cx : pick_center();
      r.past_end    = tidy ? (i >= n - tail) : 1'($urandom_range(0, 1));
      r.row_last    = tidy ? (i == n - 1) : ($urandom_range(0, 7) == 0);
      send_row(r);
    end
  endtask

  initial begin
    int target;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = REG_PIXEL_SCALE;
    cfg_data   = '0;
    item_valid = 1'b0;
    item_beat  = '0;
    calm       = 1'b0;
    long_hold  = 0;
    rows_sent  = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // reset settings: zero, extremes, rounding halves, past end, lone last row
    send_row(mk(128, 128, 0, 100, 0, 0));
    send_row(mk(255, 0, 255, 100, 0, 0));
    send_row(mk(0, 255, 255, 100, 0, 0));
    send_row(mk(128, 129, 128, 100, 0, 0));
    send_row(mk(128, 127, 128, 100, 0, 0));
    send_row(mk(0, 0, 0, 0, 1, 0));
    send_row(mk(255, 255, 0, 8191, 1, 1));
    send_row(mk(200, 50, 64, 4000, 0, 1));
    settle();

    // largest scale, positive fill, oversized width
    set_config(65535, FILL_POS, 0, 8191, 16383);
    send_row(mk(255, 255, 0, 4096, 0, 0));
    send_row(mk(0, 0, 0, 4096, 0, 0));
    send_row(mk(255, 0, 128, 4096, 0, 0));
    send_row(mk(64, 200, 10, 4096, 1, 1));
    settle();

    // zero scale, fill mode three, reversed, no reach, width zero
    set_config(0, FILL_NEG_ALT, 1, 0, 0);
    send_row(mk(255, 0, 255, 0, 0, 0));
    send_row(mk(10, 20, 30, 8191, 0, 1));
    settle();

    // negative fill, width one, center beyond the raster
    set_config(8192, FILL_NEG, 1, 50, 1);
    send_row(mk(0, 255, 0, 20, 0, 0));
    send_row(mk(255, 0, 0, 20, 0, 0));
    send_row(mk(128, 128, 0, 20, 1, 1));
    settle();

    set_config(20000, FILL_POS, 1, 100, 300);
    send_row(mk(30, 220, 100, 290, 0, 0));
    send_row(mk(220, 30, 100, 290, 0, 0));
    send_row(mk(128, 128, 0, 290, 0, 1));
    settle();

    for (int p = 0; p < 12; p++) begin
      random_config();
      calm = (p % 4 == 3);
      target = rows_sent + 50;
      while (rows_sent < target)
        random_trace($urandom_range(0, 4) != 0,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24));
      send_row(mk($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  pick_center(), 0, 1));
      settle();
    end

    // receiver holds off while rows keep coming, so the row queue fills up
    set_config(4096, FILL_POS, 0, 64, 8192);
    calm = 1'b1;
    @(posedge clk);
    long_hold = 120;
    @(negedge clk);
    random_trace(1'b1, 40);
    settle();

    if (mismatches == 0 && spans_owed == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
sv/wtsr_pkg.sv
sv/wtsr_queue.sv
sv/wtsr_front.sv
sv/wtsr_back.sv
sv/wiggle_trace_span_raster_core.sv
bench/wtsr_span_checker.sv
bench/tb_wiggle_trace_span_raster_core.sv
